>>> hdl/lwbm_pkg.sv
package lwbm_pkg;

  // Startup countdown length in ticks; zero disables the countdown and the init pulse.
  localparam logic [3:0] STARTUP_TICKS = 4'd10;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 8;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_BATTERY_THRESHOLD = 3'd0,
    CFG_PING_PERIOD       = 3'd1,
    CFG_RETRY_PERIOD      = 3'd2,
    CFG_FAIL_LIMIT        = 3'd3,
    CFG_WATCHDOG_ENABLE   = 3'd4
  } cfg_addr_e;

  localparam logic [7:0] BATTERY_THRESHOLD_RST = 8'h71;
  localparam logic [7:0] PING_PERIOD_RST       = 8'd8;
  localparam logic [7:0] RETRY_PERIOD_RST      = 8'd2;
  localparam logic [7:0] FAIL_LIMIT_RST        = 8'd13;

  typedef struct packed {
    logic [7:0] battery_level;
    logic       on_charge;
    logic       ping_ok;
  } tick_in_t;

  typedef struct packed {
    logic low_battery;
    logic sensor_init;
    logic ping_used;
    logic led_write;
    logic led_red;
    logic reboot;
  } tick_out_t;

endpackage

>>> hdl/link_watchdog_battery_monitor.sv
// Link watchdog and battery monitor, one result beat for every tick beat.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one tick: battery
// level, charger flag and the reachability answer for that tick. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one result beat per tick with
// the low battery flag, the sensor init pulse, the check strobe, the LED write
// and the reboot request.
//
// The result of an accepted tick is presented from the next edge on, from a single
// output register. Throughput is one tick per cycle while the receiver takes each
// beat; the counter updates are 8-bit adds and compares and a 4-bit decrement.
// When the receiver stalls, the output register holds its beat and in_ready_o
// stays low until that beat is taken; in_ready_o is high whenever the output
// register is empty or is being drained in the same cycle.
//
// Reset restores the register defaults, reloads the startup countdown and
// clears all watchdog counters and the output valid flag. Configuration writes
// through cfg_we_i / cfg_addr_i / cfg_wdata_i take effect at the next edge.
module link_watchdog_battery_monitor
  import lwbm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tick_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tick_out_t               out_data_o
);

  logic [7:0] battery_threshold_q, ping_period_q, retry_period_q, fail_limit_q;
  logic       watchdog_enable_q;

  logic [3:0] startup_left_q, startup_left_d;
  logic [7:0] period_count_q, period_count_d;
  logic [7:0] retry_count_q, retry_count_d;
  logic [7:0] fail_count_q, fail_count_d;
  logic       led_red_now_q, led_red_now_d;

  logic       out_valid_q;
  tick_out_t  out_data_q, res_d;
  logic       accept;

  logic [7:0] period_inc, retry_inc, fail_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign period_inc = period_count_q + 8'd1;
  assign retry_inc  = retry_count_q + 8'd1;
  assign fail_inc   = fail_count_q + 8'd1;

  always_comb begin
    startup_left_d = startup_left_q;
    period_count_d = period_count_q;
    retry_count_d  = retry_count_q;
    fail_count_d   = fail_count_q;
    led_red_now_d  = led_red_now_q;
    res_d          = '0;
    res_d.low_battery = (in_data_i.battery_level <= battery_threshold_q) &&
                        !in_data_i.on_charge;

    if (startup_left_q != 4'd0) begin
      startup_left_d    = startup_left_q - 4'd1;
      res_d.sensor_init = (startup_left_q == 4'd1);
    end else if (watchdog_enable_q) begin
      if (fail_count_q != 8'd0) begin
        // Fail mode: toggle the LED every tick, retry when the period is reached.
        retry_count_d   = retry_inc;
        led_red_now_d   = !led_red_now_q;
        res_d.led_write = 1'b1;
        res_d.led_red   = !led_red_now_q;
        if (retry_inc >= retry_period_q) begin
          retry_count_d   = 8'd0;
          res_d.ping_used = 1'b1;
          if (in_data_i.ping_ok) begin
            fail_count_d  = 8'd0;
            led_red_now_d = 1'b0;
            res_d.led_red = 1'b0;
          end else if (fail_inc >= fail_limit_q) begin
            res_d.reboot = 1'b1;
            fail_count_d = 8'd0;
          end else begin
            fail_count_d = fail_inc;
          end
        end
      end else begin
        period_count_d = period_inc;
        if (period_inc >= ping_period_q) begin
          period_count_d  = 8'd0;
          retry_count_d   = 8'd0;
          res_d.ping_used = 1'b1;
          if (!in_data_i.ping_ok) begin
            fail_count_d    = 8'd1;
            led_red_now_d   = 1'b1;
            res_d.led_write = 1'b1;
            res_d.led_red   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      battery_threshold_q <= BATTERY_THRESHOLD_RST;
      ping_period_q       <= PING_PERIOD_RST;
      retry_period_q      <= RETRY_PERIOD_RST;
      fail_limit_q        <= FAIL_LIMIT_RST;
      watchdog_enable_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BATTERY_THRESHOLD: battery_threshold_q <= cfg_wdata_i;
        CFG_PING_PERIOD:       ping_period_q       <= cfg_wdata_i;
        CFG_RETRY_PERIOD:      retry_period_q      <= cfg_wdata_i;
        CFG_FAIL_LIMIT:        fail_limit_q        <= cfg_wdata_i;
        CFG_WATCHDOG_ENABLE:   watchdog_enable_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_left_q <= STARTUP_TICKS;
      period_count_q <= 8'd0;
      retry_count_q  <= 8'd0;
      fail_count_q   <= 8'd0;
      led_red_now_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        startup_left_q <= startup_left_d;
        period_count_q <= period_count_d;
        retry_count_q  <= retry_count_d;
        fail_count_q   <= fail_count_d;
        led_red_now_q  <= led_red_now_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res_d;
    end
  end

  // A red LED value is only ever reported together with an LED write.
  a_led_red_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.led_red |-> out_data_q.led_write)
    else $error("led_red set without led_write");

  // A reboot is only requested on a tick that made a failed check.
  a_reboot_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.reboot |-> out_data_q.ping_used && out_data_q.led_write)
    else $error("reboot without a check in fail mode");

  // The init pulse comes from the countdown, which excludes any watchdog activity.
  a_init_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.sensor_init |-> !out_data_q.ping_used && !out_data_q.led_write)
    else $error("sensor_init together with watchdog activity");

  // A reboot leaves fail mode.
  a_reboot_clears_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_d.reboot |=> fail_count_q == 8'd0)
    else $error("fail count not cleared after reboot");

  // An accepted tick always produces a result beat at the next edge.
  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted tick produced no result beat");

endmodule
